>>> rtl/core/csmab_pkg.sv
// Package: shared types and constants for the CSMA backoff node.
`timescale 1ns / 1ps

package csmab_pkg;

    localparam int unsigned QUEUE_DEPTH = 1024;
    localparam int unsigned EXP_CAP     = 16;

    localparam int unsigned EXP_W    = 5;
    localparam int unsigned THRESH_W = 17;
    localparam int unsigned RAND_W   = 16;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] QUEUE_FULL = COUNT_W'(QUEUE_DEPTH);
    localparam logic [EXP_W-1:0]   EXP_LIMIT  = EXP_W'(EXP_CAP);

    typedef enum logic [2:0] {
        OP_DECIDE    = 3'd0,
        OP_COLLISION = 3'd1,
        OP_SUCCESS   = 3'd2,
        OP_TICK      = 3'd3,
        OP_ARRIVAL   = 3'd4,
        OP_POP       = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_EXP  = 2'd0,
        CFG_PERSIST  = 2'd1,
        CFG_ARRIVAL  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic              channel_busy;
        logic [RAND_W-1:0] random_value;
    } in_word_t;

    typedef struct packed {
        logic               attempt_transmit;
        logic               frame_added;
        logic               frame_dropped;
        logic [RAND_W-1:0]  backoff_now;
        logic [EXP_W-1:0]   collisions_now;
        logic [COUNT_W-1:0] frames_waiting;
    } out_word_t;

    typedef struct packed {
        logic [EXP_W-1:0]    max_backoff_exponent;
        logic [THRESH_W-1:0] persist_threshold;
        logic [THRESH_W-1:0] arrival_threshold;
    } cfg_t;

    typedef struct packed {
        logic [EXP_W-1:0]   collision_count;
        logic [RAND_W-1:0]  backoff_counter;
        logic [COUNT_W-1:0] queue_count;
    } node_state_t;

endpackage

>>> rtl/core/csma_backoff_node_unit.sv
// Top level: p-persistent CSMA node with truncated binary exponential backoff.
`timescale 1ns / 1ps

//  channel | direction | handshake           | word
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | in_data  (operation, busy, random)
//  out     | output    | out_valid/out_stall | out_data (flags, state after event)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One event word a cycle while the result register is not stalled. An
//  accepted word lands in the input register; once the result register is
//  free, the event logic updates the node state and fills the result register.
//  Reset clears the node state, both valid flags and loads the register
//  defaults (exponent 10, persistence 32768, arrival 6554). While the result
//  register is stalled, the input register still takes one more word.

module csma_backoff_node_unit
    import csmab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [THRESH_W-1:0]   cfg_data
);

    cfg_t        cfg_reg;
    node_state_t state_reg;
    node_state_t state_next;
    in_word_t    in_data_reg;
    logic        in_valid_reg;
    out_word_t   out_data_reg;
    out_word_t   result;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    // Result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    // Move the held event through the event logic into the result register.
    assign advance  = in_valid_reg && out_free;
    // Hold off new words only when the input register is full and cannot drain.
    assign in_stall = in_valid_reg && !out_free;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    csmab_event_logic u_event (
        .word       (in_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_backoff_exponent <= EXP_W'(10);
            cfg_reg.persist_threshold    <= THRESH_W'(32768);
            cfg_reg.arrival_threshold    <= THRESH_W'(6554);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_EXP: cfg_reg.max_backoff_exponent <= cfg_data[EXP_W-1:0];
                CFG_PERSIST: cfg_reg.persist_threshold    <= cfg_data;
                CFG_ARRIVAL: cfg_reg.arrival_threshold    <= cfg_data;
                default:     cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    // Control: valid flags and node state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> rtl/core/csmab_event_logic.sv
// Event logic: next node state and result word for one event.
`timescale 1ns / 1ps

module csmab_event_logic
    import csmab_pkg::*;
(
    input  in_word_t    word,
    input  cfg_t        cfg,
    input  node_state_t state,
    output node_state_t state_next,
    output out_word_t   result
);

    logic [EXP_W-1:0]    ceiling;
    logic [EXP_W:0]      coll_inc;
    logic [EXP_W-1:0]    coll_new;
    logic [RAND_W:0]     window_mask;
    logic                persist_hit;
    logic                arrival_hit;
    logic                attempt;
    logic                added;
    logic                dropped;

    always_comb
    begin
        // clamp exponent ceiling to the width of the random draw
        ceiling     = (cfg.max_backoff_exponent > EXP_LIMIT) ? EXP_LIMIT
                                                             : cfg.max_backoff_exponent;
        coll_inc    = {1'b0, state.collision_count} + (EXP_W+1)'(1);
        coll_new    = (coll_inc < {1'b0, ceiling}) ? coll_inc[EXP_W-1:0] : ceiling;
        window_mask = ((RAND_W+1)'(1) << coll_new) - (RAND_W+1)'(1);
        persist_hit = {1'b0, word.random_value} < cfg.persist_threshold;
        arrival_hit = {1'b0, word.random_value} < cfg.arrival_threshold;
    end

    always_comb
    begin
        state_next = state;
        attempt    = 1'b0;
        added      = 1'b0;
        dropped    = 1'b0;
        unique case (word.operation)
            OP_DECIDE:
            begin
                attempt = (state.queue_count != '0) && (state.backoff_counter == '0)
                          && !word.channel_busy && persist_hit;
            end
            OP_COLLISION:
            begin
                state_next.collision_count = coll_new;
                state_next.backoff_counter = word.random_value & window_mask[RAND_W-1:0];
            end
            OP_SUCCESS:
            begin
                state_next.collision_count = '0;
                state_next.backoff_counter = '0;
            end
            OP_TICK:
            begin
                if (state.backoff_counter != '0)
                begin
                    state_next.backoff_counter = state.backoff_counter - RAND_W'(1);
                end
            end
            OP_ARRIVAL:
            begin
                if (arrival_hit)
                begin
                    if (state.queue_count < QUEUE_FULL)
                    begin
                        state_next.queue_count = state.queue_count + COUNT_W'(1);
                        added = 1'b1;
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
            end
            OP_POP:
            begin
                if (state.queue_count != '0)
                begin
                    state_next.queue_count = state.queue_count - COUNT_W'(1);
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.attempt_transmit = attempt;
        result.frame_added      = added;
        result.frame_dropped    = dropped;
        result.backoff_now      = state_next.backoff_counter;
        result.collisions_now   = state_next.collision_count;
        result.frames_waiting   = state_next.queue_count;
    end

endmodule
